/* hdl/modem_escape_expander_defines.svh */
// Assertion macros shared by the modem escape expander modules.
`ifndef MODEM_ESCAPE_EXPANDER_DEFINES_SVH
`define MODEM_ESCAPE_EXPANDER_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge outside reset.
`define MEE_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("modem escape expander check failed");

// Property checked on every rising edge, reset included.
`define MEE_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("modem escape expander check failed");

`else

`define MEE_ASSERT(label, clk, rst, prop)
`define MEE_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

/* hdl/mee_pkg.sv */
package mee_pkg;

  // Action codes carried with each result.
  localparam logic [2:0] ACT_SEND      = 3'd0;
  localparam logic [2:0] ACT_PAUSE     = 3'd1;
  localparam logic [2:0] ACT_DROP      = 3'd2;
  localparam logic [2:0] ACT_BREAK     = 3'd3;
  localparam logic [2:0] ACT_END_NO_CR = 3'd4;

  // Escape parser phases.
  localparam logic [1:0] PH_TEXT = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_HEX1 = 2'd2;
  localparam logic [1:0] PH_HEX2 = 2'd3;

  // Characters of interest.
  localparam logic [7:0] CH_END       = 8'h00;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CASE_BIT     = 8'h20;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_X   = 8'h78;
  localparam logic [7:0] CH_UPPER_P   = 8'h50;
  localparam logic [7:0] CH_UPPER_D   = 8'h44;
  localparam logic [7:0] CH_UPPER_B   = 8'h42;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] TEN          = 8'd10;

  // One result request.
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] byte_value;
    logic [7:0] pause_tenths;
    logic       is_last;
  } result_t;

  // Value of a hex digit, either case; anything else counts as zero.
  function automatic logic [3:0] digit_value(input logic [7:0] ch);
    logic [7:0] low;
    logic [7:0] sum;
    begin
      low = ch | CASE_BIT;
      sum = TEN + (low - CH_LOWER_A);
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        digit_value = ch[3:0];
      end else if (low >= CH_LOWER_A && low <= CH_LOWER_F) begin
        digit_value = sum[3:0];
      end else begin
        digit_value = 4'd0;
      end
    end
  endfunction

endpackage

/* hdl/mee_decode.sv */
`include "modem_escape_expander_defines.svh"

module mee_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          char_code,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                slot_free,
  output logic                load,
  output mee_pkg::result_t    res
);

  // Input register and escape parser state.
  logic       in_full;
  logic [7:0] in_char;
  logic [1:0] phase;
  logic [1:0] phase_next;
  logic       hex_is_pause;
  logic       hex_is_pause_next;
  logic [3:0] high_nibble;
  logic [3:0] high_nibble_next;
  logic       produce;
  logic       process;
  logic [3:0] low_digit;

  assign low_digit = mee_pkg::digit_value(in_char);

  // Decode the held character against the current phase.
  always_comb begin
    phase_next        = phase;
    hex_is_pause_next = hex_is_pause;
    high_nibble_next  = high_nibble;
    produce           = 1'b0;
    res.action        = mee_pkg::ACT_SEND;
    res.byte_value    = 8'd0;
    res.pause_tenths  = 8'd0;
    res.is_last       = 1'b0;
    case (phase)
      mee_pkg::PH_TEXT: begin
        if (in_char == mee_pkg::CH_END) begin
          produce        = 1'b1;
          res.byte_value = mee_pkg::CH_CR;
          res.is_last    = 1'b1;
        end else if (in_char == mee_pkg::CH_BACKSLASH) begin
          phase_next = mee_pkg::PH_ESC;
        end else begin
          produce        = 1'b1;
          res.byte_value = in_char;
        end
      end
      mee_pkg::PH_ESC: begin
        phase_next = mee_pkg::PH_TEXT;
        produce    = 1'b1;
        case (in_char)
          mee_pkg::CH_END: begin
            res.action  = mee_pkg::ACT_END_NO_CR;
            res.is_last = 1'b1;
          end
          mee_pkg::CH_LOWER_R: res.byte_value = mee_pkg::CH_CR;
          mee_pkg::CH_LOWER_N: res.byte_value = mee_pkg::CH_LF;
          mee_pkg::CH_LOWER_X: begin
            produce           = 1'b0;
            hex_is_pause_next = 1'b0;
            phase_next        = mee_pkg::PH_HEX1;
          end
          mee_pkg::CH_UPPER_P: begin
            produce           = 1'b0;
            hex_is_pause_next = 1'b1;
            phase_next        = mee_pkg::PH_HEX1;
          end
          mee_pkg::CH_UPPER_D: res.action = mee_pkg::ACT_DROP;
          mee_pkg::CH_UPPER_B: res.action = mee_pkg::ACT_BREAK;
          default:             res.byte_value = in_char;
        endcase
      end
      mee_pkg::PH_HEX1: begin
        if (in_char == mee_pkg::CH_END) begin
          phase_next     = mee_pkg::PH_TEXT;
          produce        = 1'b1;
          res.byte_value = mee_pkg::CH_CR;
          res.is_last    = 1'b1;
        end else begin
          high_nibble_next = low_digit;
          phase_next       = mee_pkg::PH_HEX2;
        end
      end
      default: begin
        phase_next = mee_pkg::PH_TEXT;
        produce    = 1'b1;
        if (in_char == mee_pkg::CH_END) begin
          res.byte_value = mee_pkg::CH_CR;
          res.is_last    = 1'b1;
        end else if (hex_is_pause) begin
          res.action       = mee_pkg::ACT_PAUSE;
          res.pause_tenths = {high_nibble, low_digit};
        end else begin
          res.byte_value = {high_nibble, low_digit};
        end
      end
    endcase
  end

  // A held character moves on when its result, if any, has a free slot.
  assign process  = in_full && (!produce || slot_free);
  assign load     = process && produce;
  assign in_ready = !in_full || process;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_char <= char_code;
    end
  end

  // Parser state advances once per processed character.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= mee_pkg::PH_TEXT;
      hex_is_pause <= 1'b0;
      high_nibble  <= 4'd0;
    end else if (process) begin
      phase        <= phase_next;
      hex_is_pause <= hex_is_pause_next;
      high_nibble  <= high_nibble_next;
    end
  end

  // The end of a string always returns the parser to plain text.
  `MEE_ASSERT(a_end_to_text, clk, rst,
    (process && in_char == mee_pkg::CH_END) |=> (phase == mee_pkg::PH_TEXT))
  // The end of a string always yields a final result.
  `MEE_ASSERT(a_end_is_last, clk, rst,
    (process && in_char == mee_pkg::CH_END) |-> (load && res.is_last))
  // A second hex digit always completes an escape with a result.
  `MEE_ASSERT(a_hex2_emits, clk, rst,
    (process && phase == mee_pkg::PH_HEX2) |-> load)

endmodule

/* hdl/mee_out_reg.sv */
`include "modem_escape_expander_defines.svh"

module mee_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  mee_pkg::result_t res,
  output logic             slot_free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       action,
  output logic [7:0]       byte_value,
  output logic [7:0]       pause_tenths,
  output logic             is_last
);

  logic             held;
  mee_pkg::result_t data;

  // The slot can take a new result when empty or being emptied this cycle.
  assign slot_free = !held || out_ready;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (slot_free) begin
      held <= load;
    end
    if (load && slot_free) begin
      data <= res;
    end
  end

  assign out_valid    = held;
  assign action       = data.action;
  assign byte_value   = data.byte_value;
  assign pause_tenths = data.pause_tenths;
  assign is_last      = data.is_last;

  // A result is only written into a free slot.
  `MEE_ASSERT(a_load_free, clk, rst, load |-> slot_free)
  // Only defined actions leave the block.
  `MEE_ASSERT(a_action_range, clk, rst,
    held |-> (data.action <= mee_pkg::ACT_END_NO_CR))
  // Pause and send byte fields never both carry a value.
  `MEE_ASSERT(a_fields_exclusive, clk, rst,
    held |-> (data.byte_value == 8'd0 || data.pause_tenths == 8'd0))

endmodule

/* hdl/modem_escape_expander.sv */
// Modem command string expander.
// The input channel (char_code, in_valid, in_ready) takes one character of a
// command string per request; code zero marks the end of the string.
// The output channel (action, byte_value, pause_tenths, is_last, out_valid,
// out_ready) gives at most one action per character: send a byte, pause,
// drop the line, send a break, or end without a carriage return.
// Escape starts and first hex digits give no result.
// A character is held in the input register, and its decoded result is then
// written into the result register once that slot is free; the result is shown
// and can be taken from the result register.
// Throughput is one character per cycle while the receiver takes results, set
// by the single decode pass between the two registers.
// Reset empties both registers and returns the parser to plain text.
// When the receiver stalls, the result register holds its request; a
// character that needs no result still moves on, and one that needs a result
// waits in the input register, which then stops accepting.
module modem_escape_expander (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_code,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [2:0] action,
  output logic [7:0] byte_value,
  output logic [7:0] pause_tenths,
  output logic       is_last,
  output logic       out_valid,
  input  logic       out_ready
);

  logic             slot_free;
  logic             load;
  mee_pkg::result_t res;

  mee_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .char_code (char_code),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .slot_free (slot_free),
    .load      (load),
    .res       (res)
  );

  mee_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .res          (res),
    .slot_free    (slot_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .action       (action),
    .byte_value   (byte_value),
    .pause_tenths (pause_tenths),
    .is_last      (is_last)
  );

endmodule

/* tb/modem_escape_expander_checker.sv */
`timescale 1ns / 1ps

module modem_escape_expander_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  char_code,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  action,
  input  logic [7:0]  byte_value,
  input  logic [7:0]  pause_tenths,
  input  logic        is_last,
  input  logic        out_valid,
  input  logic        out_ready,
  output int unsigned failures,
  output int unsigned outstanding
);

  localparam int unsigned MAX_REPORTS = 10;

  // Own copy of the escape parser state.
  logic [1:0] parse_phase;
  logic       pause_escape;
  logic [3:0] upper_digit;

  // Actions still owed by the block, oldest first.
  mee_pkg::result_t pending_actions[$];

  int unsigned actions_checked;

  initial begin
    failures = 0;
    outstanding = 0;
    actions_checked = 0;
    parse_phase = mee_pkg::PH_TEXT;
    pause_escape = 1'b0;
    upper_digit = 4'd0;
  end

  // Value of one hex digit character, either case; anything else is zero.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] folded;
    logic [7:0] offset;
    folded = c | mee_pkg::CASE_BIT;
    offset = folded - mee_pkg::CH_LOWER_A + mee_pkg::TEN;
    if (c >= mee_pkg::CH_ZERO && c <= mee_pkg::CH_NINE) begin
      return c[3:0];
    end
    if (folded >= mee_pkg::CH_LOWER_A && folded <= mee_pkg::CH_LOWER_F) begin
      return offset[3:0];
    end
    return 4'd0;
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endtask

  // Advances the parser by one character and queues the action it causes, if any.
  task automatic expand_char(input logic [7:0] c);
    mee_pkg::result_t act;
    logic             produces;
    act = '0;
    produces = 1'b1;
    case (parse_phase)
      mee_pkg::PH_TEXT: begin
        if (c == mee_pkg::CH_END) begin
          act.byte_value = mee_pkg::CH_CR;
          act.is_last = 1'b1;
        end else if (c == mee_pkg::CH_BACKSLASH) begin
          parse_phase = mee_pkg::PH_ESC;
          produces = 1'b0;
        end else begin
          act.byte_value = c;
        end
      end
      mee_pkg::PH_ESC: begin
        parse_phase = mee_pkg::PH_TEXT;
        case (c)
          mee_pkg::CH_END: begin
            act.action = mee_pkg::ACT_END_NO_CR;
            act.is_last = 1'b1;
          end
          mee_pkg::CH_LOWER_R: act.byte_value = mee_pkg::CH_CR;
          mee_pkg::CH_LOWER_N: act.byte_value = mee_pkg::CH_LF;
          mee_pkg::CH_LOWER_X: begin
            pause_escape = 1'b0;
            parse_phase = mee_pkg::PH_HEX1;
            produces = 1'b0;
          end
          mee_pkg::CH_UPPER_P: begin
            pause_escape = 1'b1;
            parse_phase = mee_pkg::PH_HEX1;
            produces = 1'b0;
          end
          mee_pkg::CH_UPPER_D: act.action = mee_pkg::ACT_DROP;
          mee_pkg::CH_UPPER_B: act.action = mee_pkg::ACT_BREAK;
          default: act.byte_value = c;
        endcase
      end
      mee_pkg::PH_HEX1: begin
        if (c == mee_pkg::CH_END) begin
          // The half-read escape is dropped and the string ends as usual.
          parse_phase = mee_pkg::PH_TEXT;
          act.byte_value = mee_pkg::CH_CR;
          act.is_last = 1'b1;
        end else begin
          upper_digit = hex_nibble(c);
          parse_phase = mee_pkg::PH_HEX2;
          produces = 1'b0;
        end
      end
      default: begin
        parse_phase = mee_pkg::PH_TEXT;
        if (c == mee_pkg::CH_END) begin
          act.byte_value = mee_pkg::CH_CR;
          act.is_last = 1'b1;
        end else if (pause_escape) begin
          act.action = mee_pkg::ACT_PAUSE;
          act.pause_tenths = {upper_digit, hex_nibble(c)};
        end else begin
          act.byte_value = {upper_digit, hex_nibble(c)};
        end
      end
    endcase
    if (produces) begin
      pending_actions.push_back(act);
    end
  endtask

  // Compares one accepted result request with the oldest owed action.
  task automatic check_action();
    mee_pkg::result_t want;
    if (pending_actions.size() == 0) begin
      note_failure($sformatf(
        "result %0d not expected: action %0d byte %02h pause %02h last %0b",
        actions_checked, action, byte_value, pause_tenths, is_last));
    end else begin
      want = pending_actions.pop_front();
      if (action !== want.action || byte_value !== want.byte_value ||
          pause_tenths !== want.pause_tenths || is_last !== want.is_last) begin
        note_failure($sformatf(
          "result %0d: expected action %0d byte %02h pause %02h last %0b, got %0d %02h %02h %0b",
          actions_checked, want.action, want.byte_value, want.pause_tenths,
          want.is_last, action, byte_value, pause_tenths, is_last));
      end
    end
    actions_checked++;
  endtask

  // Results are checked before the character taken at the same edge is predicted,
  // since a character's own action can never leave in the cycle it arrives.
  always @(posedge clk) begin
    if (rst) begin
      parse_phase = mee_pkg::PH_TEXT;
      pause_escape = 1'b0;
      upper_digit = 4'd0;
      pending_actions.delete();
    end else begin
      if (out_valid && out_ready) begin
        check_action();
      end
      if (in_valid && in_ready) begin
        expand_char(char_code);
      end
    end
    outstanding <= pending_actions.size();
  end

endmodule

/* tb/modem_escape_expander_test.sv */
`timescale 1ns / 1ps

module modem_escape_expander_test;

  localparam int unsigned TOTAL_CHARS  = 540;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam logic [7:0]  CH_UPPER_A   = 8'h41;
  localparam logic [7:0]  CH_UPPER_F   = 8'h46;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] char_code = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] action;
  logic [7:0] byte_value;
  logic [7:0] pause_tenths;
  logic       is_last;
  logic       out_valid;
  logic       out_ready = 1'b0;

  int unsigned failures;
  int unsigned outstanding;
  int unsigned chars_sent = 0;
  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 83;
  logic        hold_req = 1'b0;

  modem_escape_expander i_dut (
    .clk          (clk),
    .rst          (rst),
    .char_code    (char_code),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .byte_value   (byte_value),
    .pause_tenths (pause_tenths),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

  modem_escape_expander_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .char_code    (char_code),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .byte_value   (byte_value),
    .pause_tenths (pause_tenths),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .failures     (failures),
    .outstanding  (outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off once it is requested.
  initial begin : result_sink
    int unsigned held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_req && held < HOLD_CYCLES) begin
        out_ready <= 1'b0;
        held++;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Ends the run when no request has moved on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Offers one character after a random gap and returns at the edge that takes it.
  task automatic offer_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    chars_sent++;
  endtask

  task automatic offer_escape(input logic [7:0] c);
    offer_char(mee_pkg::CH_BACKSLASH);
    offer_char(c);
  endtask

  function automatic logic [7:0] pick_digit_char();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 40) begin
      return mee_pkg::CH_ZERO + 8'($urandom_range(9));
    end else if (k < 65) begin
      return CH_UPPER_A + 8'($urandom_range(5));
    end else if (k < 90) begin
      return mee_pkg::CH_LOWER_A + 8'($urandom_range(5));
    end
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] pick_plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == mee_pkg::CH_BACKSLASH);
    return c;
  endfunction

  // One command string built from random characters and escapes, usually ended cleanly.
  task automatic offer_command_string();
    int unsigned kind;
    repeat ($urandom_range(10)) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        offer_char(pick_plain_char());
      end else if (kind < 45) begin
        offer_escape($urandom_range(1) ? mee_pkg::CH_LOWER_R : mee_pkg::CH_LOWER_N);
      end else if (kind < 70) begin
        offer_escape($urandom_range(1) ? mee_pkg::CH_LOWER_X : mee_pkg::CH_UPPER_P);
        offer_char(pick_digit_char());
        offer_char(pick_digit_char());
      end else if (kind < 80) begin
        offer_escape($urandom_range(1) ? mee_pkg::CH_UPPER_D : mee_pkg::CH_UPPER_B);
      end else begin
        offer_escape(8'($urandom_range(1, 255)));
      end
    end
    // Now and then the string stops right after a backslash or inside a hex escape.
    kind = $urandom_range(99);
    if (kind < 8) begin
      offer_escape(mee_pkg::CH_END);
    end else if (kind < 16) begin
      offer_escape($urandom_range(1) ? mee_pkg::CH_LOWER_X : mee_pkg::CH_UPPER_P);
      if (kind < 12) begin
        offer_char(pick_digit_char());
      end
      offer_char(mee_pkg::CH_END);
    end else begin
      offer_char(mee_pkg::CH_END);
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Top of the code range as plain text, both line escapes and a normal end.
    offer_char(8'hFF);
    offer_escape(mee_pkg::CH_LOWER_R);
    offer_escape(mee_pkg::CH_LOWER_N);
    offer_char(mee_pkg::CH_END);
    // Hex byte in mixed case, a pause whose first digit is a backslash, drop, break,
    // an escaped ordinary byte, then a backslash straight before the end.
    offer_escape(mee_pkg::CH_LOWER_X);
    offer_char(mee_pkg::CH_LOWER_F);
    offer_char(CH_UPPER_F);
    offer_escape(mee_pkg::CH_UPPER_P);
    offer_char(mee_pkg::CH_BACKSLASH);
    offer_char(mee_pkg::CH_LOWER_A);
    offer_escape(mee_pkg::CH_UPPER_D);
    offer_escape(mee_pkg::CH_UPPER_B);
    offer_escape(8'hFF);
    offer_escape(mee_pkg::CH_END);
    // The end arriving while the first and while the second hex digit is awaited.
    offer_escape(mee_pkg::CH_LOWER_X);
    offer_char(mee_pkg::CH_END);
    offer_escape(mee_pkg::CH_UPPER_P);
    offer_char(mee_pkg::CH_NINE);
    offer_char(mee_pkg::CH_END);

    // Random part in three idling regimes; the long hold-off opens the last one.
    while (chars_sent < TOTAL_CHARS) begin
      if (chars_sent >= 2 * TOTAL_CHARS / 3) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        hold_req <= 1'b1;
      end else if (chars_sent >= TOTAL_CHARS / 3) begin
        send_idle_pct <= 83;
        recv_idle_pct <= 38;
      end
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 8)) offer_char(8'($urandom_range(255)));
      end else begin
        offer_command_string();
      end
    end
    in_valid <= 1'b0;

    // Wait for every owed action, then let any stray results show.
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/mee_pkg.sv
hdl/mee_decode.sv
hdl/mee_out_reg.sv
hdl/modem_escape_expander.sv
tb/modem_escape_expander_checker.sv
tb/modem_escape_expander_test.sv
